// ===== rtl/scfr_pkg.sv =====
package scfr_pkg;

	localparam int HDR_BYTES   = 5;
	localparam int BYTE_IDX_W  = 8;
	localparam int CFG_INDEX_W = 8;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ACT_ARM  = 2'd0,
		ACT_BYTE = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD     = 2'd1,
		STAT_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SYNC_CODE = 8'd0,
		CFG_TIMEOUT   = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_data;
	} in_beat_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [7:0]  command;
		logic [15:0] frame_length;
		logic [7:0]  data_out;
		logic [7:0]  byte_index;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [15:0]            wdata;
	} cfg_beat_t;

	typedef struct packed {
		logic [15:0] sync_code;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// input register contents handed to the frame logic
	typedef struct packed {
		logic     valid;
		in_beat_t beat;
	} stage_t;

endpackage

// ===== rtl/scfr_stream_if.sv =====
interface scfr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/start_code_frame_receiver.sv =====
// Start-code frame receiver. An arm beat (action 0) opens a frame; byte beats
// (action 1) are then hunted for the high start byte, checked against the low
// start byte, and parsed as command byte and big-endian 16-bit length. Each
// later byte leaves as a payload beat (kind 0) with its index; the byte whose
// index equals the length is the checksum, unverified, and closes the frame
// with status ok. A wrong second start byte or reaching the BUFFER_BYTES limit
// closes it as bad; idle ticks (action 2) reaching timeout_ticks close it as
// timeout. After a close, bytes and ticks are dropped until the next arm.
// Rate: one input beat per clock, sustained while results are taken. A beat
// passes the input register and then the result register; all per-beat decisions
// sit between those two. in_ch.ready follows out_ch.ready combinationally
// through the input register, so a stalled result holds up at most one beat.
// No memory, no clearing pass after reset. Config writes (cfg.index 0 start
// code, 1 timeout) are always taken and belong only between frames when idle.
module start_code_frame_receiver #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	scfr_stream_if.sink   in_ch,
	scfr_stream_if.source out_ch,
	scfr_stream_if.sink   cfg
);
	import scfr_pkg::*;

	cfg_t   regs;    // live register values
	stage_t stage;   // input register contents
	logic   advance; // input register drains into the frame logic

	scfr_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	scfr_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.advance (advance),
		.stage   (stage)
	);

	// header parse, index/length compare, timeout count, result register
	scfr_frame_core #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_frame_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.regs    (regs),
		.advance (advance),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	// a beat held in the input register is never dropped while results stall
	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		stage.valid && out_ch.valid && !out_ch.ready |=> stage.valid)
		else $error("input beat lost during output stall");

	// payload beats always carry ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.kind == KIND_DATA |-> out_ch.data.status == STAT_OK)
		else $error("payload beat with non-ok status");

	// timeout closes carry no byte
	a_timeout_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status == STAT_TIMEOUT
		|-> out_ch.data.data_out == '0 && out_ch.data.byte_index == '0)
		else $error("timeout result carries byte data");
`endif

endmodule

// ===== rtl/scfr_cfg_regs.sv =====
module scfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	scfr_stream_if.sink   cfg,
	output scfr_pkg::cfg_t regs
);
	import scfr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_code     <= '0;
			regs_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_SYNC_CODE: regs_q.sync_code     <= cfg.data.wdata;
				CFG_TIMEOUT:   regs_q.timeout_ticks <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/scfr_in_stage.sv =====
module scfr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	scfr_stream_if.sink     in_ch,
	input  logic            advance,
	output scfr_pkg::stage_t stage
);
	import scfr_pkg::*;

	logic     valid_s1;
	in_beat_t beat_s1;

	// take a new beat when the register is empty or drains this cycle
	assign in_ch.ready = !valid_s1 || advance;
	assign stage.valid = valid_s1;
	assign stage.beat  = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			beat_s1 <= in_ch.data;
		end
	end

endmodule

// ===== rtl/scfr_frame_core.sv =====
module scfr_frame_core #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scfr_pkg::stage_t stage,
	input  scfr_pkg::cfg_t   regs,
	output logic             advance,
	scfr_stream_if.source    out_ch
);
	import scfr_pkg::*;

	localparam int POS_W = $clog2(BUFFER_BYTES);

	logic             armed_q, armed_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0]      idle_q, idle_n;
	logic [7:0]       cmd_q, cmd_n;
	logic [15:0]      len_q, len_n;

	logic             res_valid_s2;
	out_beat_t        res_s2;

	logic             has_res;
	out_beat_t        res;
	logic             take;
	logic [7:0]       b;
	logic [7:0]       idx;
	logic [POS_W:0]   pos_room;

	assign advance      = stage.valid && (!res_valid_s2 || out_ch.ready);
	assign out_ch.valid = res_valid_s2;
	assign out_ch.data  = res_s2;
	assign b            = stage.beat.rx_data;
	assign idx          = BYTE_IDX_W'(pos_q) - BYTE_IDX_W'(HDR_BYTES);

	always_comb begin
		armed_n  = armed_q;
		pos_n    = pos_q;
		idle_n   = idle_q;
		cmd_n    = cmd_q;
		len_n    = len_q;
		has_res  = 1'b0;
		take     = 1'b0;
		pos_room = '0;
		res      = '0;
		case (stage.beat.action)
			ACT_ARM: begin
				armed_n = 1'b1;
				pos_n   = '0;
				idle_n  = '0;
				cmd_n   = '0;
				len_n   = '0;
			end
			ACT_TICK: begin
				if (armed_q) begin
					idle_n = idle_q + 16'd1;
					if (idle_n >= regs.timeout_ticks || idle_n == '0) begin
						armed_n    = 1'b0;
						has_res    = 1'b1;
						res.kind   = KIND_END;
						res.status = STAT_TIMEOUT;
					end
				end
			end
			ACT_BYTE: begin
				if (armed_q) begin
					take = 1'b1;
					case (pos_q)
						POS_W'(0): begin
							// hunting: skip anything but the high start byte
							if (b != regs.sync_code[15:8]) take = 1'b0;
						end
						POS_W'(1): begin
							if (b != regs.sync_code[7:0]) begin
								take          = 1'b0;
								armed_n       = 1'b0;
								has_res       = 1'b1;
								res.kind      = KIND_END;
								res.status    = STAT_BAD;
								res.data_out  = b;
							end
						end
						POS_W'(2): cmd_n = b;
						POS_W'(3): len_n = {b, 8'h00};
						POS_W'(4): len_n = {len_q[15:8], b};
						default: begin
							if (16'(idx) == len_q) begin
								take           = 1'b0;
								armed_n        = 1'b0;
								has_res        = 1'b1;
								res.kind       = KIND_END;
								res.status     = STAT_OK;
								res.data_out   = b;
								res.byte_index = idx;
							end
						end
					endcase
					if (take) begin
						pos_n    = pos_q + POS_W'(1);
						pos_room = {1'b0, pos_n} + (POS_W+1)'(HDR_BYTES);
						if (pos_room >= (POS_W+1)'(BUFFER_BYTES)) begin
							armed_n        = 1'b0;
							has_res        = 1'b1;
							res.kind       = KIND_END;
							res.status     = STAT_BAD;
							res.data_out   = b;
							res.byte_index = (pos_q >= POS_W'(HDR_BYTES)) ? idx : '0;
						end else if (pos_n > POS_W'(HDR_BYTES)) begin
							has_res        = 1'b1;
							res.kind       = KIND_DATA;
							res.status     = STAT_OK;
							res.data_out   = b;
							res.byte_index = idx;
						end
					end
				end
			end
			default: ;
		endcase
		res.command      = cmd_n;
		res.frame_length = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			pos_q        <= '0;
			idle_q       <= '0;
			cmd_q        <= '0;
			len_q        <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				armed_q      <= armed_n;
				pos_q        <= pos_n;
				idle_q       <= idle_n;
				cmd_q        <= cmd_n;
				len_q        <= len_n;
				res_valid_s2 <= has_res;
			end else if (out_ch.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== tb/sv/start_code_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

import scfr_pkg::*;

class frame_scoreboard;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	int unsigned buffer_bytes;
	logic [15:0] sync_code;
	logic [15:0] timeout_ticks;
	logic        armed;
	logic [8:0]  position;
	logic [15:0] idle_count;
	logic [7:0]  cmd_held;
	logic [15:0] length_held;
	out_beat_t   pending_results[$];
	int          mismatches;
	int          results_checked;

	function new(int unsigned bytes);
		buffer_bytes = bytes;
		sync_code = 16'h0000;
		timeout_ticks = TIMEOUT_RESET;
		armed = 1'b0;
		position = '0;
		idle_count = '0;
		cmd_held = '0;
		length_held = '0;
		mismatches = 0;
		results_checked = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [15:0] value);
		if (idx == CFG_SYNC_CODE)
			sync_code = value;
		else if (idx == CFG_TIMEOUT)
			timeout_ticks = value;
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	// true when the beat changes state (arm, or a byte/tick in an open frame)
	function bit beat_counts(in_beat_t b);
		return b.action == ACT_ARM || (armed && b.action != ACT_UNUSED);
	endfunction

	function void push_result(kind_t k, status_t s, logic [7:0] d, logic [7:0] idx);
		out_beat_t r;
		r.kind = k;
		r.status = s;
		r.command = cmd_held;
		r.frame_length = length_held;
		r.data_out = d;
		r.byte_index = idx;
		pending_results.push_back(r);
	endfunction

	// advance the frame state by one accepted input beat
	function void absorb_beat(in_beat_t b);
		logic [7:0] d;
		logic [8:0] full_idx;
		logic [7:0] idx;
		d = b.rx_data;
		idx = '0;
		if (b.action == ACT_ARM) begin
			armed = 1'b1;
			position = '0;
			idle_count = '0;
			cmd_held = '0;
			length_held = '0;
			return;
		end
		if (!armed || b.action == ACT_UNUSED)
			return;
		if (b.action == ACT_TICK) begin
			idle_count = idle_count + 16'd1;
			if (idle_count >= timeout_ticks || idle_count == 16'd0) begin
				armed = 1'b0;
				push_result(KIND_END, STAT_TIMEOUT, 8'h00, 8'h00);
			end
			return;
		end
		case (position)
			9'd0: begin
				if (d != sync_code[15:8])
					return;
			end
			9'd1: begin
				if (d != sync_code[7:0]) begin
					armed = 1'b0;
					push_result(KIND_END, STAT_BAD, d, 8'h00);
					return;
				end
			end
			9'd2: cmd_held = d;
			9'd3: length_held = {d, 8'h00};
			9'd4: length_held[7:0] = d;
			default: begin
				full_idx = position - 9'(HDR_BYTES);
				idx = full_idx[7:0];
				if ({7'b0, full_idx} == length_held) begin
					armed = 1'b0;
					push_result(KIND_END, STAT_OK, d, idx);
					return;
				end
			end
		endcase
		position = position + 9'd1;
		if (int'(position) + HDR_BYTES >= int'(buffer_bytes)) begin
			armed = 1'b0;
			push_result(KIND_END, STAT_BAD, d, idx);
		end else if (position > 9'(HDR_BYTES)) begin
			push_result(KIND_DATA, STAT_OK, d, idx);
		end
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at result %0d: %s", results_checked, msg);
	endtask

	task compare_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task check_result(out_beat_t got);
		out_beat_t want;
		results_checked++;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected beat %0h", got));
			return;
		end
		want = pending_results.pop_front();
		compare_field("kind", 16'(got.kind), 16'(want.kind));
		compare_field("status", 16'(got.status), 16'(want.status));
		compare_field("command", 16'(got.command), 16'(want.command));
		compare_field("frame_length", got.frame_length, want.frame_length);
		compare_field("data_out", 16'(got.data_out), 16'(want.data_out));
		compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
	endtask
endclass

module start_code_frame_receiver_tb;
	localparam int BUFFER_BYTES  = 256;
	localparam int ITEM_TARGET   = 650;
	localparam int CYCLE_LIMIT   = 400000;
	// receiver hold-off: long enough to back up the block and stall the sender
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT       = 40;
	localparam int DRAIN_CYCLES  = 6;
	// room a long frame needs in the item budget
	localparam int LONG_ROOM     = 260;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	scfr_stream_if #(.payload_t(in_beat_t))  in_ch ();
	scfr_stream_if #(.payload_t(out_beat_t)) out_ch ();
	scfr_stream_if #(.payload_t(cfg_beat_t)) cfg_ch ();

	start_code_frame_receiver #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	frame_scoreboard sb = new(BUFFER_BYTES);

	// Idle stretches toggle now and then so that some runs go back to back.
	bit send_gaps_on = 1'b1;
	bit recv_stalls_on = 1'b1;
	int items_used = 0;
	int frame_count = 0;

	always #6 clk = ~clk;

	// Stimulus and input state are set to known values at time zero.
	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		out_ch.ready <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
	end

	function automatic in_beat_t mk_beat(logic [1:0] act, logic [7:0] d);
		in_beat_t b;
		b.action = act;
		b.rx_data = d;
		return b;
	endfunction

	// Offer one beat, with a random gap first; valid stays high across
	// back-to-back beats so it is never dropped and raised in the same step.
	task automatic send_item(in_beat_t b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_gaps_on = !send_gaps_on;
		gap = send_gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (sb.beat_counts(b))
			items_used++;
		sb.absorb_beat(b);
	endtask

	task automatic send(logic [1:0] act, logic [7:0] d);
		send_item(mk_beat(act, d));
	endtask

	// Register writes only with the block idle: all results in, then the
	// pipeline latency again in case an arm or tick is still in flight.
	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, wdata: value};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	// One frame attempt: arm, optional noise while hunting, start code (low
	// byte sometimes wrong), command, length, payload and checksum. Short
	// frames get ticks and sometimes a cut-off (the next arm then lands mid-frame);
	// unused actions come in any frame; long frames end at or just inside the buffer limit.
	task automatic send_frame(bit long_one);
		in_beat_t    seq[$];
		logic [15:0] len;
		logic [7:0]  hi, lo, d;
		int          body;
		hi = sb.sync_code[15:8];
		lo = sb.sync_code[7:0];
		seq.push_back(mk_beat(ACT_ARM, 8'($urandom)));
		repeat ($urandom_range(0, 3)) begin
			d = 8'($urandom);
			if (d == hi)
				d = d ^ 8'h01;
			seq.push_back(mk_beat(ACT_BYTE, d));
		end
		seq.push_back(mk_beat(ACT_BYTE, hi));
		if ($urandom_range(0, 9) == 0)
			lo = lo ^ 8'($urandom_range(1, 255));
		seq.push_back(mk_beat(ACT_BYTE, lo));
		if (long_one) begin
			case ($urandom_range(0, 3))
				0: len = 16'd245;  // checksum lands on the last slot, ends ok
				1: len = 16'd246;  // one more than fits
				2: len = 16'hFFFF;
				default: len = 16'($urandom_range(247, 65534));
			endcase
		end else begin
			len = 16'($urandom_range(0, 12));
		end
		seq.push_back(mk_beat(ACT_BYTE, 8'($urandom)));
		seq.push_back(mk_beat(ACT_BYTE, len[15:8]));
		seq.push_back(mk_beat(ACT_BYTE, len[7:0]));
		body = (len > 16'd247) ? 248 : int'(len) + 1;
		repeat (body) seq.push_back(mk_beat(ACT_BYTE, 8'($urandom)));
		if (!long_one && $urandom_range(0, 11) == 0)
			seq = seq[0:$urandom_range(0, seq.size() - 1)];
		foreach (seq[i]) begin
			if (!long_one && $urandom_range(0, 7) == 0)
				send(ACT_TICK, 8'($urandom));
			if ($urandom_range(0, 29) == 0)
				send(ACT_UNUSED, 8'($urandom));
			send_item(seq[i]);
		end
		// strays after the frame closed: must be dropped
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 2))
				0: send(ACT_BYTE, 8'($urandom));
				1: send(ACT_TICK, 8'($urandom));
				default: send(ACT_UNUSED, 8'($urandom));
			endcase
		end
		frame_count++;
	endtask

	// Result side: random stall per beat, one long hold-off early on.
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_stalls_on = !recv_stalls_on;
			stall = recv_stalls_on ? $urandom_range(0, 14) : 0;
			if (sb.results_checked == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			sb.check_result(out_ch.data);
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int          phase;
		int          phase_start;
		logic [15:0] code;
		logic [15:0] ticks;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings: start code 0000, timeout 1000.
		send(ACT_BYTE, 8'h55);     // not armed: dropped
		send(ACT_TICK, 8'h00);
		send(ACT_UNUSED, 8'hFF);
		send(ACT_ARM, 8'hAA);
		send(ACT_BYTE, 8'h12);     // hunting skips it
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'hFF);     // command
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h01);     // length 1
		send(ACT_BYTE, 8'hFF);     // payload index 0
		send(ACT_BYTE, 8'h00);     // checksum at index 1, ends ok
		send(ACT_BYTE, 8'h00);     // after close: dropped
		send(ACT_ARM, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h7E);     // bad low start byte
		send(ACT_ARM, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'hA5);
		send(ACT_UNUSED, 8'h00);
		send(ACT_ARM, 8'h00);      // re-arm mid-frame
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h3C);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00);     // length 0
		send(ACT_BYTE, 8'h80);     // checksum at index 0

		// Random part, phase by phase under different settings.
		phase = 0;
		while (items_used < ITEM_TARGET) begin
			case (phase)
				0: begin code = 16'hFFFF; ticks = 16'd1; end
				1: begin code = 16'h0000; ticks = 16'hFFFF; end
				2: begin code = 16'hA5A5; ticks = 16'd3; end
				3: begin code = 16'($urandom); ticks = 16'd2; end
				default: begin
					code = 16'($urandom);
					case ($urandom_range(0, 5))
						0: ticks = 16'hFFFF;
						1: ticks = TIMEOUT_RESET;
						default: ticks = 16'($urandom_range(1, 40));
					endcase
				end
			endcase
			write_reg(CFG_SYNC_CODE, code);
			write_reg(CFG_TIMEOUT, ticks);
			phase_start = items_used;
			while (items_used - phase_start < 90 && items_used < ITEM_TARGET)
				send_frame(frame_count % 20 == 7 &&
					items_used + LONG_ROOM <= ITEM_TARGET);
			phase++;
		end

		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
